[hw/rtl/alpha_blend_blit_with_clipping_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sprite blitter
// Shared concurrent assertion forms, clocked and gated by synchronous reset.
// ----------------------------------------------------------------------------
`ifndef ALPHA_BLEND_BLIT_WITH_CLIPPING_DEFINES_SVH
`define ALPHA_BLEND_BLIT_WITH_CLIPPING_DEFINES_SVH

// Same-cycle implication
`define ABB_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ABB_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/abb_pkg.sv]
// ----------------------------------------------------------------------------
// Sprite blitter package
// Widths, register codes, pixel types and the per-channel blend function.
// ----------------------------------------------------------------------------
package abb_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int QUEUE_DEPTH    = 4;
  localparam int REG_W          = 13;
  localparam int CHAN_W         = 8;
  localparam int INDEX_W        = 24;
  localparam int CFG_IDX_W      = 3;

  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'd0;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_DEST_X        = 3'd2,
    REG_DEST_Y        = 3'd3,
    REG_SPRITE_WIDTH  = 3'd4,
    REG_SPRITE_HEIGHT = 3'd5,
    REG_BLEND_ENABLE  = 3'd6
  } cfg_reg_t;

  // Pixel operation chosen by the front end
  typedef enum logic [1:0] {
    OP_COPY  = 2'd0,
    OP_SKIP  = 2'd1,
    OP_BLEND = 2'd2
  } pix_op_t;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] alpha;
  } bgra_t;

  typedef struct packed {
    logic [REG_W-1:0]        screen_width;
    logic [REG_W-1:0]        screen_height;
    logic signed [REG_W-1:0] dest_x;
    logic signed [REG_W-1:0] dest_y;
    logic [REG_W-1:0]        sprite_width;
    logic [REG_W-1:0]        sprite_height;
    logic                    blend_enable;
  } blit_cfg_t;

  // Classified pixel handed from front end to back end
  typedef struct packed {
    pix_op_t          op;
    logic             on_screen;
    logic             last;
    logic [REG_W-1:0] x;
    logic [REG_W-1:0] y;
    bgra_t            src;
    bgra_t            dst;
  } blit_item_t;

  typedef struct packed {
    logic last;
    logic at_origin;
  } front_stat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // dst + floor(a * (s - d) / 256), modulo 256
  function automatic logic [CHAN_W-1:0] blend_chan(input logic [CHAN_W-1:0] s,
                                                   input logic [CHAN_W-1:0] d,
                                                   input logic [CHAN_W-1:0] a);
    logic signed [CHAN_W:0]       diff;
    logic signed [2*CHAN_W+1:0]   prod;
    logic signed [CHAN_W+1:0]     q;
    logic [CHAN_W-1:0]            res;
    diff = $signed({1'b0, s}) - $signed({1'b0, d});
    prod = $signed({{(CHAN_W+2){1'b0}}, a})
         * $signed({{(CHAN_W+1){diff[CHAN_W]}}, diff});
    q    = prod[2*CHAN_W+1:CHAN_W];
    res  = d + q[CHAN_W-1:0];
    return res;
  endfunction

endpackage

[hw/rtl/abb_in_if.sv]
// ----------------------------------------------------------------------------
// Sprite pixel input channel
// Valid/ready channel carrying one sprite pixel and the screen pixel below it.
// ----------------------------------------------------------------------------
interface abb_in_if;
  import abb_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] src_blue;
  logic [CHAN_W-1:0] src_green;
  logic [CHAN_W-1:0] src_red;
  logic [CHAN_W-1:0] src_alpha;
  logic [CHAN_W-1:0] dst_blue;
  logic [CHAN_W-1:0] dst_green;
  logic [CHAN_W-1:0] dst_red;
  logic [CHAN_W-1:0] dst_alpha;

  modport source (
    output valid, src_blue, src_green, src_red, src_alpha,
    output dst_blue, dst_green, dst_red, dst_alpha,
    input  ready
  );

  modport sink (
    input  valid, src_blue, src_green, src_red, src_alpha,
    input  dst_blue, dst_green, dst_red, dst_alpha,
    output ready
  );
endinterface

[hw/rtl/abb_out_if.sv]
// ----------------------------------------------------------------------------
// Screen write output channel
// Valid/ready channel carrying one screen write request per transaction.
// ----------------------------------------------------------------------------
interface abb_out_if;
  import abb_pkg::*;

  logic               valid;
  logic               ready;
  logic               write_enable;
  logic [INDEX_W-1:0] screen_index;
  logic [CHAN_W-1:0]  out_blue;
  logic [CHAN_W-1:0]  out_green;
  logic [CHAN_W-1:0]  out_red;
  logic [CHAN_W-1:0]  out_alpha;
  logic               last_pixel;

  modport source (
    output valid, write_enable, screen_index,
    output out_blue, out_green, out_red, out_alpha, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, write_enable, screen_index,
    input  out_blue, out_green, out_red, out_alpha, last_pixel,
    output ready
  );
endinterface

[hw/rtl/alpha_blend_blit_with_clipping.sv]
// ----------------------------------------------------------------------------
// Alpha blend sprite blitter with screen clipping
// Sprite pixels in raster order come in on in_ch together with the screen
// pixel beneath each; one screen write request per pixel leaves on out_ch.
// Geometry and blend mode are set through cfg_we / cfg_index / cfg_wdata
// while the blitter is idle; writes do not disturb the raster counters.
// A pixel accepted on in_ch is written into the queue and then loaded into the
// back end's result register, from which out_ch offers it.
// Throughput: one pixel per clock while out_ch accepts; the front end, the
// four-entry queue and the back end's result register each pass one
// transaction a cycle. When out_ch stalls the result register holds and the
// queue fills; in_ch ready drops only once the queue holds four pixels.
// Reset: raster counters return to the sprite origin, the queue and result
// register empty, and registers take 640x480 screen, sprite 64x64 at (0,0),
// blending on.
// ----------------------------------------------------------------------------
`include "alpha_blend_blit_with_clipping_defines.svh"

module alpha_blend_blit_with_clipping #(
  parameter int COORD_BITS  = abb_pkg::COORD_BITS_DEF,
  parameter int QUEUE_DEPTH = abb_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [abb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [abb_pkg::REG_W-1:0]     cfg_wdata,
  abb_in_if.sink                        in_ch,
  abb_out_if.source                     out_ch
);
  import abb_pkg::*;

  localparam int ITEM_W = $bits(blit_item_t);

  blit_cfg_t   cfg_r;
  front_stat_t f_stat;
  queue_stat_t q_stat;
  blit_item_t  f_item;
  blit_item_t  q_item;
  logic [ITEM_W-1:0] q_data;
  logic        in_fire;
  logic        back_pop;
  bgra_t       in_src, in_dst;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width  <= 13'd640;
      cfg_r.screen_height <= 13'd480;
      cfg_r.dest_x        <= '0;
      cfg_r.dest_y        <= '0;
      cfg_r.sprite_width  <= 13'd64;
      cfg_r.sprite_height <= 13'd64;
      cfg_r.blend_enable  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  cfg_r.screen_width  <= cfg_wdata;
        REG_SCREEN_HEIGHT: cfg_r.screen_height <= cfg_wdata;
        REG_DEST_X:        cfg_r.dest_x        <= cfg_wdata;
        REG_DEST_Y:        cfg_r.dest_y        <= cfg_wdata;
        REG_SPRITE_WIDTH:  cfg_r.sprite_width  <= cfg_wdata;
        REG_SPRITE_HEIGHT: cfg_r.sprite_height <= cfg_wdata;
        REG_BLEND_ENABLE:  cfg_r.blend_enable  <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Input transaction
  assign in_ch.ready = !q_stat.full;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    in_src.blue  = in_ch.src_blue;
    in_src.green = in_ch.src_green;
    in_src.red   = in_ch.src_red;
    in_src.alpha = in_ch.src_alpha;
    in_dst.blue  = in_ch.dst_blue;
    in_dst.green = in_ch.dst_green;
    in_dst.red   = in_ch.dst_red;
    in_dst.alpha = in_ch.dst_alpha;
  end

  abb_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .fire  (in_fire),
    .src   (in_src),
    .dst   (in_dst),
    .item  (f_item),
    .stat  (f_stat)
  );

  abb_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_data (f_item),
    .pop       (back_pop),
    .pop_data  (q_data),
    .stat      (q_stat)
  );

  assign q_item = blit_item_t'(q_data);

  abb_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .screen_width (cfg_r.screen_width),
    .item_valid   (!q_stat.empty),
    .item         (q_item),
    .item_pop     (back_pop),
    .out_ch       (out_ch)
  );

  // Checks
  `ABB_ASSERT_IMPL(a_pop_nonempty, clk, rst_n, back_pop, !q_stat.empty, "pop from empty queue")
  `ABB_ASSERT_IMPL(a_drain_when_free, clk, rst_n, !q_stat.empty && (!out_ch.valid || out_ch.ready), back_pop, "queued pixel not moved to free result register")
  `ABB_ASSERT_NEXT(a_last_wraps, clk, rst_n, in_fire && f_stat.last, f_stat.at_origin, "raster counters did not wrap after last pixel")

endmodule

[hw/rtl/abb_front.sv]
// ----------------------------------------------------------------------------
// Sprite blitter front end
// Tracks sprite column and row, clips against the screen, classifies pixels.
// ----------------------------------------------------------------------------
module abb_front #(
  parameter int COORD_BITS = abb_pkg::COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  abb_pkg::blit_cfg_t  cfg,
  input  logic                fire,
  input  abb_pkg::bgra_t      src,
  input  abb_pkg::bgra_t      dst,
  output abb_pkg::blit_item_t item,
  output abb_pkg::front_stat_t stat
);
  import abb_pkg::*;

  localparam int EXT_W = ((COORD_BITS > REG_W) ? COORD_BITS : REG_W) + 1;
  localparam int POS_W = EXT_W + 1;
  localparam logic [EXT_W-1:0] SIZE_LIM = {{(EXT_W-1){1'b0}}, 1'b1} << COORD_BITS;
  localparam logic [EXT_W-1:0] ONE_EXT  = {{(EXT_W-1){1'b0}}, 1'b1};

  // Clamp a size register to 1 .. 2^COORD_BITS
  function automatic logic [EXT_W-1:0] eff_size(input logic [REG_W-1:0] v);
    logic [EXT_W-1:0] ve;
    ve = {{(EXT_W-REG_W){1'b0}}, v};
    if (v == '0) begin
      return ONE_EXT;
    end else if (ve > SIZE_LIM) begin
      return SIZE_LIM;
    end
    return ve;
  endfunction

  logic [COORD_BITS-1:0] col_r, col_nxt;
  logic [COORD_BITS-1:0] row_r, row_nxt;
  logic [EXT_W-1:0]      w_eff, h_eff, col_inc, row_inc;
  logic                  row_end, last;
  logic [POS_W-1:0]      pos_x, pos_y;
  logic                  on_screen;
  pix_op_t               op;

  // Sprite position and end-of-row / end-of-sprite detection
  always_comb begin
    w_eff   = eff_size(cfg.sprite_width);
    h_eff   = eff_size(cfg.sprite_height);
    col_inc = {{(EXT_W-COORD_BITS){1'b0}}, col_r} + ONE_EXT;
    row_inc = {{(EXT_W-COORD_BITS){1'b0}}, row_r} + ONE_EXT;
    row_end = col_inc >= w_eff;
    last    = row_end && (row_inc >= h_eff);
  end

  // Screen position and clipping
  always_comb begin
    pos_x = {{(POS_W-REG_W){cfg.dest_x[REG_W-1]}}, cfg.dest_x}
          + {{(POS_W-COORD_BITS){1'b0}}, col_r};
    pos_y = {{(POS_W-REG_W){cfg.dest_y[REG_W-1]}}, cfg.dest_y}
          + {{(POS_W-COORD_BITS){1'b0}}, row_r};
    on_screen = !pos_x[POS_W-1] && !pos_y[POS_W-1]
             && (pos_x < {{(POS_W-REG_W){1'b0}}, cfg.screen_width})
             && (pos_y < {{(POS_W-REG_W){1'b0}}, cfg.screen_height});
  end

  // Classify the pixel
  always_comb begin
    if (!cfg.blend_enable || (src.alpha == ALPHA_OPAQUE)) begin
      op = OP_COPY;
    end else if (src.alpha == ALPHA_CLEAR) begin
      op = OP_SKIP;
    end else begin
      op = OP_BLEND;
    end
  end

  always_comb begin
    item.op        = op;
    item.on_screen = on_screen;
    item.last      = last;
    item.x         = pos_x[REG_W-1:0];
    item.y         = pos_y[REG_W-1:0];
    item.src       = src;
    item.dst       = dst;
    stat.last      = last;
    stat.at_origin = (col_r == '0) && (row_r == '0);
  end

  // Advance the raster counters
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (fire) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = last ? '0 : row_inc[COORD_BITS-1:0];
      end else begin
        col_nxt = col_inc[COORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

[hw/rtl/abb_queue.sv]
// ----------------------------------------------------------------------------
// Sprite blitter item queue
// Small flop-based FIFO decoupling the front end from the back end.
// ----------------------------------------------------------------------------
module abb_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = abb_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [WIDTH-1:0]     push_data,
  input  logic                 pop,
  output logic [WIDTH-1:0]     pop_data,
  output abb_pkg::queue_stat_t stat
);
  import abb_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data   = slot_r[rd_ptr_r];
  assign stat.full  = (cnt_r == CNT_FULL);
  assign stat.empty = (cnt_r == '0);

endmodule

[hw/rtl/abb_back.sv]
// ----------------------------------------------------------------------------
// Sprite blitter back end
// Blends colors, forms the screen index and holds the result register.
// ----------------------------------------------------------------------------
module abb_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [abb_pkg::REG_W-1:0]  screen_width,
  input  logic                       item_valid,
  input  abb_pkg::blit_item_t        item,
  output logic                       item_pop,
  abb_out_if.source                  out_ch
);
  import abb_pkg::*;

  logic                 out_valid_r;
  logic                 we_r, we_nxt;
  logic [INDEX_W-1:0]   idx_r, idx_nxt;
  bgra_t                pix_r, pix_nxt;
  logic                 last_r;
  logic [2*REG_W-1:0]   row_base;
  logic                 load;

  // Take a new item when the result register is free or being drained
  assign load     = item_valid && (!out_valid_r || out_ch.ready);
  assign item_pop = load;

  // Screen index, zero when clipped
  always_comb begin
    row_base = {{REG_W{1'b0}}, item.y} * {{REG_W{1'b0}}, screen_width};
    idx_nxt  = '0;
    if (item.on_screen) begin
      idx_nxt = row_base[INDEX_W-1:0] + {{(INDEX_W-REG_W){1'b0}}, item.x};
    end
  end

  // Color result and write enable
  always_comb begin
    we_nxt  = item.on_screen;
    pix_nxt = item.src;
    case (item.op)
      OP_SKIP: begin
        pix_nxt = item.dst;
        we_nxt  = 1'b0;
      end
      OP_BLEND: begin
        pix_nxt.blue  = blend_chan(item.src.blue,  item.dst.blue,  item.src.alpha);
        pix_nxt.green = blend_chan(item.src.green, item.dst.green, item.src.alpha);
        pix_nxt.red   = blend_chan(item.src.red,   item.dst.red,   item.src.alpha);
        pix_nxt.alpha = item.dst.alpha;
      end
      default: begin
        pix_nxt = item.src;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold the result payload until taken
  always_ff @(posedge clk) begin
    if (load) begin
      we_r   <= we_nxt;
      idx_r  <= idx_nxt;
      pix_r  <= pix_nxt;
      last_r <= item.last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.write_enable = we_r;
  assign out_ch.screen_index = idx_r;
  assign out_ch.out_blue     = pix_r.blue;
  assign out_ch.out_green    = pix_r.green;
  assign out_ch.out_red      = pix_r.red;
  assign out_ch.out_alpha    = pix_r.alpha;
  assign out_ch.last_pixel   = last_r;

endmodule
